// ===== hdl/ppdf_pkg.sv =====
// Shared types, constants and register map for the pixel clock and FIFO timing block.
`timescale 1ns / 1ps
package ppdf_pkg;

  // Shared divider geometry
  localparam int DIV_W = 48;
  localparam int DVS_W = 28;
  localparam int CNT_W = $clog2(DIV_W);

  // Range limits on 8*q and post divider thresholds
  localparam logic [DIV_W-1:0] Q_MIN   = DIV_W'(16 * 8);
  localparam logic [DIV_W-1:0] Q_MAX   = DIV_W'(255 * 8);
  localparam logic [10:0]      Q_POST2 = 11'(128 * 8);
  localparam logic [10:0]      Q_POST4 = 11'(64 * 8);
  localparam logic [10:0]      Q_POST8 = 11'(32 * 8);
  localparam logic [2:0]       VSHIFT_BASE = 3'(6 - 2);

  // Register indexes
  localparam logic [2:0] REG_REF_SCALED   = 3'd0;
  localparam logic [2:0] REG_MEM_FB_DIV   = 3'd1;
  localparam logic [2:0] REG_MEM_POST_DIV = 3'd2;
  localparam logic [2:0] REG_RAS_DELAY    = 3'd3;
  localparam logic [2:0] REG_PF_DELAY     = 3'd4;
  localparam logic [2:0] REG_FIFO_DEPTH   = 3'd5;
  localparam logic [2:0] REG_LOOP_LAT     = 3'd6;
  localparam logic [2:0] REG_PANEL_WIDTH  = 3'd7;

  // Register reset values
  localparam logic [24:0] RST_REF_SCALED   = 25'd1000000;
  localparam logic [8:0]  RST_MEM_FB_DIV   = 9'd128;
  localparam logic [3:0]  RST_MEM_POST_DIV = 4'd1;
  localparam logic [4:0]  RST_RAS_DELAY    = 5'd10;
  localparam logic [4:0]  RST_PF_DELAY     = 5'd9;
  localparam logic [6:0]  RST_FIFO_DEPTH   = 7'd32;
  localparam logic [3:0]  RST_LOOP_LAT     = 4'd8;
  localparam logic [11:0] RST_PANEL_WIDTH  = 12'd1024;

  typedef struct packed {
    logic [17:0] pixel_period;
    logic [5:0]  pixel_bits;
    logic [11:0] mode_width;
  } in_item_t;

  typedef struct packed {
    logic        out_of_range;
    logic [1:0]  post_div_code;
    logic [7:0]  feedback_div;
    logic [15:0] fifo_on;
    logic [15:0] fifo_off;
    logic [2:0]  fifo_precision;
    logic [15:0] fifo_xclks;
    logic [3:0]  latency_out;
  } out_item_t;

  typedef struct packed {
    logic [24:0] ref_scaled;
    logic [8:0]  mem_fb_div;
    logic [3:0]  mem_post_div;
    logic [4:0]  ras_delay;
    logic [4:0]  page_fault_delay;
    logic [6:0]  fifo_depth;
    logic [3:0]  loop_latency;
    logic [11:0] panel_width;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_QDIV,
    ST_QWAIT,
    ST_MFB,
    ST_MBPP,
    ST_MPMUL,
    ST_MPDVD,
    ST_MRAS,
    ST_HALVE,
    ST_MDEPTH,
    ST_TDIV,
    ST_TWAIT,
    ST_PREC,
    ST_MDEPTH1,
    ST_OFFDIV,
    ST_OFFWAIT,
    ST_ONDIV,
    ST_ONWAIT,
    ST_T2DIV,
    ST_T2WAIT,
    ST_XDIV,
    ST_XWAIT,
    ST_MQDIV,
    ST_MQWAIT,
    ST_FIN1,
    ST_FIN2,
    ST_DONE
  } ppdf_state_t;

endpackage

// ===== hdl/pixel_pll_and_display_fifo_timing.sv =====
// Top level: sequencer and datapath for pixel PLL dividers and display FIFO timing.
// One transaction in gives one result transaction out. Each item runs seven divisions one
// after another on a single restoring divider, with common halving, bit length counting
// and multiplies and final rounding on one shared multiplier in between. An out-of-range
// request returns after the first division, a zero period without any division. in_ready
// is high only while the sequencer is idle; a finished result waits in the output register
// and the next item is accepted meanwhile. Configuration is to be written through the
// APB-style port while idle; the block itself does not enforce this. There is no clearing
// pass after reset.
`timescale 1ns / 1ps
module pixel_pll_and_display_fifo_timing (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ppdf_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ppdf_pkg::out_item_t   out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [4:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import ppdf_pkg::*;

  function automatic logic [15:0] sat16(input logic [49:0] x);
    sat16 = (x > 50'd65535) ? 16'hFFFF : x[15:0];
  endfunction

  cfg_t        cfg;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  ppdf_state_t state_r, state_nxt;
  logic [17:0] period_r, period_nxt;
  logic [5:0]  bits_r, bits_nxt;
  logic [11:0] mwidth_r, mwidth_nxt;
  logic        oor_r, oor_nxt;
  logic [1:0]  code_r, code_nxt;
  logic [7:0]  fb_r, fb_nxt;
  logic [23:0] mul_r, mul_nxt;
  logic [27:0] dvd_r, dvd_nxt;
  logic [16:0] rmul_r, rmul_nxt;
  logic [11:0] rdiv_r, rdiv_nxt;
  logic [30:0] prod_r, prod_nxt;
  logic [47:0] t_r, t_nxt;
  logic [5:0]  bl_r, bl_nxt;
  logic [2:0]  prec_r, prec_nxt;
  logic [47:0] off_r, off_nxt;
  logic [49:0] on_r, on_nxt;
  logic [23:0] t2_r, t2_nxt;
  logic [47:0] xclks_r, xclks_nxt;
  logic [47:0] mq_r, mq_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic        accept;
  logic        slot_free;
  logic        q_oor;
  logic [1:0]  q_code;
  logic [13:0] q_fbw;
  logic        halve_go;
  logic [2:0]  vshift0;
  logic [3:0]  vshift;
  logic        xs_neg;
  logic [2:0]  shl;
  logic [2:0]  ush;
  logic [23:0] rmul_sh;
  logic [10:0] pfd_sh;
  logic [49:0] umask;
  logic [47:0] mul48;
  logic [47:0] lowbit;
  logic [49:0] onm;
  logic [49:0] on_sum;
  logic [47:0] off_sub;
  logic [23:0] mult_a;
  logic [11:0] mult_b;
  logic [35:0] mult_p;

  ppdf_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  ppdf_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Range check and divider pick on 8*q
  assign q_oor  = (div_rsp.quot < Q_MIN) || (div_rsp.quot > Q_MAX);
  assign q_code = 2'(div_rsp.quot[10:0] < Q_POST2) + 2'(div_rsp.quot[10:0] < Q_POST4)
                + 2'(div_rsp.quot[10:0] < Q_POST8);
  assign q_fbw  = {3'b000, div_rsp.quot[10:0]} << q_code;

  assign halve_go = ((mul_r != '0) || (dvd_r != '0)) && !mul_r[0] && !dvd_r[0];

  // Shift amounts; precision seven turns the extra shift into a right shift by one
  assign vshift0 = (bits_r == '0) ? (VSHIFT_BASE - 3'd1) : VSHIFT_BASE;
  assign vshift  = 4'(vshift0) + 4'd6 - 4'(prec_r);
  assign xs_neg  = (prec_r == 3'd7);
  assign shl     = 3'd6 - prec_r;
  assign ush     = xs_neg ? 3'd0 : shl;
  assign rmul_sh = xs_neg ? 24'(rmul_r >> 1) : (24'(rmul_r) << shl);
  assign pfd_sh  = xs_neg ? 11'(cfg.page_fault_delay >> 1)
                          : (11'(cfg.page_fault_delay) << shl);
  assign umask   = ~((50'd1 << ush) - 50'd1);
  assign mul48   = 48'(mul_r);
  assign lowbit  = 48'd1 << vshift0;

  // Final on point arithmetic
  assign onm     = (on_r >= 50'(t2_r)) ? on_r : 50'(t2_r);
  assign on_sum  = onm + (50'(t2_r) << 1) + 50'(pfd_sh) + ((50'd1 << ush) - 50'd1);
  assign off_sub = (off_r > mq_r) ? (off_r - mq_r) : 48'd0;

  // Shared multiplier
  assign mult_p = mult_a * mult_b;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (accept) state_nxt = ST_QDIV;
      ST_QDIV:    state_nxt = (period_r == '0) ? ST_DONE : ST_QWAIT;
      ST_QWAIT:   if (div_rsp.done) state_nxt = q_oor ? ST_DONE : ST_MFB;
      ST_MFB:     state_nxt = ST_MBPP;
      ST_MBPP:    state_nxt = ST_MPMUL;
      ST_MPMUL:   state_nxt = ST_MPDVD;
      ST_MPDVD:   state_nxt = ST_MRAS;
      ST_MRAS:    state_nxt = ST_HALVE;
      ST_HALVE:   if (!halve_go) state_nxt = ST_MDEPTH;
      ST_MDEPTH:  state_nxt = ST_TDIV;
      ST_TDIV:    state_nxt = ST_TWAIT;
      ST_TWAIT:   if (div_rsp.done) state_nxt = ST_PREC;
      ST_PREC:    if (t_r == '0) state_nxt = ST_MDEPTH1;
      ST_MDEPTH1: state_nxt = ST_OFFDIV;
      ST_OFFDIV:  state_nxt = ST_OFFWAIT;
      ST_OFFWAIT: if (div_rsp.done) state_nxt = ST_ONDIV;
      ST_ONDIV:   state_nxt = ST_ONWAIT;
      ST_ONWAIT:  if (div_rsp.done) state_nxt = ST_T2DIV;
      ST_T2DIV:   state_nxt = ST_T2WAIT;
      ST_T2WAIT:  if (div_rsp.done) state_nxt = ST_XDIV;
      ST_XDIV:    state_nxt = ST_XWAIT;
      ST_XWAIT:   if (div_rsp.done) state_nxt = ST_MQDIV;
      ST_MQDIV:   state_nxt = ST_MQWAIT;
      ST_MQWAIT:  if (div_rsp.done) state_nxt = ST_FIN1;
      ST_FIN1:    state_nxt = ST_FIN2;
      ST_FIN2:    state_nxt = ST_DONE;
      ST_DONE:    if (slot_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and control outputs
  always_comb begin
    period_nxt    = period_r;
    bits_nxt      = bits_r;
    mwidth_nxt    = mwidth_r;
    oor_nxt       = oor_r;
    code_nxt      = code_r;
    fb_nxt        = fb_r;
    mul_nxt       = mul_r;
    dvd_nxt       = dvd_r;
    rmul_nxt      = rmul_r;
    rdiv_nxt      = rdiv_r;
    prod_nxt      = prod_r;
    t_nxt         = t_r;
    bl_nxt        = bl_r;
    prec_nxt      = prec_r;
    off_nxt       = off_r;
    on_nxt        = on_r;
    t2_nxt        = t2_r;
    xclks_nxt     = xclks_r;
    mq_nxt        = mq_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    div_req       = '0;
    mult_a        = '0;
    mult_b        = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          period_nxt = in_data.pixel_period;
          bits_nxt   = in_data.pixel_bits;
          mwidth_nxt = in_data.mode_width;
          oor_nxt    = 1'b0;
        end
      end
      ST_QDIV: begin
        if (period_r == '0) begin
          oor_nxt = 1'b1;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = 48'({cfg.ref_scaled, 2'b00});
          div_req.divisor  = 28'(period_r);
        end
      end
      ST_QWAIT: begin
        if (div_rsp.done) begin
          oor_nxt  = q_oor;
          code_nxt = q_code;
          fb_nxt   = q_fbw[10:3];
        end
      end
      ST_MFB: begin
        mul_nxt = 24'(cfg.mem_fb_div) << code_r;
        mult_a  = 24'(fb_r);
        mult_b  = 12'(cfg.mem_post_div);
        dvd_nxt = 28'(mult_p);
      end
      ST_MBPP: begin
        if (bits_r >= 6'd8) begin
          mult_a  = dvd_r[23:0];
          mult_b  = 12'(bits_r[5:2]);
          dvd_nxt = 28'(mult_p);
        end
      end
      ST_MPMUL: begin
        if (mwidth_r != '0) begin
          mult_a  = mul_r;
          mult_b  = cfg.panel_width;
          mul_nxt = 24'(mult_p);
        end
      end
      ST_MPDVD: begin
        rdiv_nxt = (mwidth_r != '0) ? mwidth_r : 12'd1;
        if (mwidth_r != '0) begin
          mult_a  = dvd_r[23:0];
          mult_b  = mwidth_r;
          dvd_nxt = 28'(mult_p);
        end
      end
      ST_MRAS: begin
        mult_a   = 24'(cfg.ras_delay);
        mult_b   = (mwidth_r != '0) ? cfg.panel_width : 12'd1;
        rmul_nxt = 17'(mult_p);
      end
      ST_HALVE: begin
        if (halve_go) begin
          mul_nxt = mul_r >> 1;
          dvd_nxt = dvd_r >> 1;
        end
      end
      ST_MDEPTH: begin
        mult_a   = mul_r;
        mult_b   = 12'(cfg.fifo_depth);
        prod_nxt = 31'(mult_p);
      end
      ST_TDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = 48'(prod_r) << vshift0;
        div_req.divisor  = dvd_r;
      end
      ST_TWAIT: begin
        if (div_rsp.done) begin
          t_nxt  = div_rsp.quot;
          bl_nxt = '0;
        end
      end
      ST_PREC: begin
        // Bit length counted one shift at a time
        if (t_r != '0) begin
          t_nxt  = t_r >> 1;
          bl_nxt = bl_r + 6'd1;
        end else if (bl_r <= 6'd5) begin
          prec_nxt = 3'd0;
        end else if (bl_r >= 6'd12) begin
          prec_nxt = 3'd7;
        end else begin
          prec_nxt = 3'(bl_r - 6'd5);
        end
      end
      ST_MDEPTH1: begin
        mult_a   = mul_r;
        mult_b   = (cfg.fifo_depth == '0) ? 12'd0 : 12'(cfg.fifo_depth - 7'd1);
        prod_nxt = 31'(mult_p);
      end
      ST_OFFDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = 48'(prod_r) << vshift;
        div_req.divisor  = dvd_r;
      end
      ST_OFFWAIT: begin
        if (div_rsp.done) begin
          off_nxt = (div_rsp.quot > lowbit) ? (div_rsp.quot - lowbit) : 48'd0;
        end
      end
      ST_ONDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = (mul48 << vshift) + 48'(dvd_r);
        div_req.divisor  = dvd_r;
      end
      ST_ONWAIT: begin
        if (div_rsp.done) on_nxt = 50'(div_rsp.quot);
      end
      ST_T2DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = 48'(rmul_sh) + 48'(rdiv_r);
        div_req.divisor  = 28'(rdiv_r);
      end
      ST_T2WAIT: begin
        if (div_rsp.done) t2_nxt = div_rsp.quot[23:0];
      end
      ST_XDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = (mul48 << (5'(vshift) + 5'd5)) + 48'(dvd_r);
        div_req.divisor  = dvd_r;
      end
      ST_XWAIT: begin
        if (div_rsp.done) xclks_nxt = div_rsp.quot;
      end
      ST_MQDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul48 << vshift;
        div_req.divisor  = dvd_r;
      end
      ST_MQWAIT: begin
        if (div_rsp.done) mq_nxt = div_rsp.quot;
      end
      ST_FIN1: begin
        on_nxt = on_sum & umask;
      end
      ST_FIN2: begin
        // Fall back below the off point when the rounded on point reaches it
        if (on_r >= (50'(off_r) & umask)) on_nxt = 50'(off_sub) & umask;
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          if (oor_r) begin
            out_data_nxt.out_of_range = 1'b1;
          end else begin
            out_data_nxt.post_div_code  = code_r;
            out_data_nxt.feedback_div   = fb_r;
            out_data_nxt.fifo_on        = sat16(on_r);
            out_data_nxt.fifo_off       = sat16(50'(off_r));
            out_data_nxt.fifo_precision = prec_r;
            out_data_nxt.fifo_xclks     = sat16(50'(xclks_r));
            out_data_nxt.latency_out    = cfg.loop_latency;
          end
        end
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    period_r   <= period_nxt;
    bits_r     <= bits_nxt;
    mwidth_r   <= mwidth_nxt;
    oor_r      <= oor_nxt;
    code_r     <= code_nxt;
    fb_r       <= fb_nxt;
    mul_r      <= mul_nxt;
    dvd_r      <= dvd_nxt;
    rmul_r     <= rmul_nxt;
    rdiv_r     <= rdiv_nxt;
    prod_r     <= prod_nxt;
    t_r        <= t_nxt;
    bl_r       <= bl_nxt;
    prec_r     <= prec_nxt;
    off_r      <= off_nxt;
    on_r       <= on_nxt;
    t2_r       <= t2_nxt;
    xclks_r    <= xclks_nxt;
    mq_r       <= mq_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== hdl/ppdf_regs.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module ppdf_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output ppdf_pkg::cfg_t     cfg
);
  import ppdf_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       wr_en;
  logic [2:0] idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = cfg_paddr[4:2];
  assign cfg        = cfg_r;

  // Write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_REF_SCALED:   cfg_nxt.ref_scaled       = cfg_pwdata[24:0];
        REG_MEM_FB_DIV:   cfg_nxt.mem_fb_div       = cfg_pwdata[8:0];
        REG_MEM_POST_DIV: cfg_nxt.mem_post_div     = cfg_pwdata[3:0];
        REG_RAS_DELAY:    cfg_nxt.ras_delay        = cfg_pwdata[4:0];
        REG_PF_DELAY:     cfg_nxt.page_fault_delay = cfg_pwdata[4:0];
        REG_FIFO_DEPTH:   cfg_nxt.fifo_depth       = cfg_pwdata[6:0];
        REG_LOOP_LAT:     cfg_nxt.loop_latency     = cfg_pwdata[3:0];
        REG_PANEL_WIDTH:  cfg_nxt.panel_width      = cfg_pwdata[11:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ref_scaled       <= RST_REF_SCALED;
      cfg_r.mem_fb_div       <= RST_MEM_FB_DIV;
      cfg_r.mem_post_div     <= RST_MEM_POST_DIV;
      cfg_r.ras_delay        <= RST_RAS_DELAY;
      cfg_r.page_fault_delay <= RST_PF_DELAY;
      cfg_r.fifo_depth       <= RST_FIFO_DEPTH;
      cfg_r.loop_latency     <= RST_LOOP_LAT;
      cfg_r.panel_width      <= RST_PANEL_WIDTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_REF_SCALED:   cfg_prdata = 32'(cfg_r.ref_scaled);
      REG_MEM_FB_DIV:   cfg_prdata = 32'(cfg_r.mem_fb_div);
      REG_MEM_POST_DIV: cfg_prdata = 32'(cfg_r.mem_post_div);
      REG_RAS_DELAY:    cfg_prdata = 32'(cfg_r.ras_delay);
      REG_PF_DELAY:     cfg_prdata = 32'(cfg_r.page_fault_delay);
      REG_FIFO_DEPTH:   cfg_prdata = 32'(cfg_r.fifo_depth);
      REG_LOOP_LAT:     cfg_prdata = 32'(cfg_r.loop_latency);
      REG_PANEL_WIDTH:  cfg_prdata = 32'(cfg_r.panel_width);
      default:          cfg_prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/ppdf_div.sv =====
// Shared restoring divider, one quotient bit per cycle; zero divisor gives all ones.
`timescale 1ns / 1ps
module ppdf_div (
  input  logic                clk,
  input  logic                rst_n,
  input  ppdf_pkg::div_req_t  req,
  output ppdf_pkg::div_rsp_t  rsp
);
  import ppdf_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dq_r, dq_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  // Trial subtract
  assign shifted = {rem_r, dq_r[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dq_nxt   = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      dq_nxt  = {dq_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = dq_r;

endmodule

// ===== hdl/ppdf_chk.sv =====
// Port-level checker for the pixel clock and FIFO timing block, with its bind.
`timescale 1ns / 1ps
module ppdf_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input ppdf_pkg::out_item_t  out_data
);
  import ppdf_pkg::*;

  // A pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // One item at a time: no second transaction right after an accepted one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // Out-of-range results carry nothing else
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_of_range |->
      out_data.fifo_on == '0 && out_data.fifo_off == '0 &&
      out_data.fifo_xclks == '0 && out_data.feedback_div == '0)
    else $error("out-of-range result with live fields");

  // Valid timing keeps the on point at or below the off point, xclks nonzero
  a_on_le_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.out_of_range |->
      out_data.fifo_on <= out_data.fifo_off && out_data.fifo_xclks != '0)
    else $error("fifo on point above off point or zero xclks");

endmodule

bind pixel_pll_and_display_fifo_timing ppdf_chk u_ppdf_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// ===== bench/testbench.sv =====
// Self-checking bench for the pixel PLL and display FIFO timing block.
`timescale 1ns / 1ps
module testbench;
  import ppdf_pkg::*;

  localparam longint unsigned DIV_ZERO = 64'hFFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 500;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  pixel_pll_and_display_fifo_timing uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Shadow copy of the register file
  cfg_t regs;
  out_item_t timing_q[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;
  int sink_hold = 0;

  // Clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL pixel_pll_and_display_fifo_timing");
      $finish;
    end
  end

  function automatic longint unsigned qdiv(longint unsigned a, longint unsigned b);
    return (b != 0) ? a / b : DIV_ZERO;
  endfunction

  function automatic longint unsigned sh(longint unsigned x, int s);
    return (s >= 0) ? (x << s) : (x >> (-s));
  endfunction

  function automatic longint unsigned floor_sub(longint unsigned a, longint unsigned b);
    return (a > b) ? a - b : 0;
  endfunction

  function automatic logic [15:0] clip16(longint unsigned x);
    return (x > 65535) ? 16'hFFFF : x[15:0];
  endfunction

  // Expected divider settings and FIFO timing for one request
  function automatic out_item_t pll_timing(in_item_t it, cfg_t c);
    out_item_t r;
    longint unsigned q, code, preal, fb, mul, dvd, rmul, rdiv, t, off, on, unit, mq, xc;
    longint unsigned period, bits, mw;
    int vs0, xs, vs, prec;
    r = '0;
    period = it.pixel_period;
    bits = it.pixel_bits;
    mw = it.mode_width;
    q = (period != 0) ? (longint'(c.ref_scaled) * 4) / period : 0;
    if (period == 0 || q < 128 || q > 2040) begin
      r.out_of_range = 1'b1;
      return r;
    end
    code = (q < 1024) + (q < 512) + (q < 256);
    preal = 1 << code;
    fb = ((q * preal) / 8) & 8'hFF;
    mul = c.mem_fb_div * preal;
    dvd = fb * c.mem_post_div;
    rmul = c.ras_delay;
    rdiv = 1;
    if (bits >= 8) dvd = dvd * (bits >> 2);
    vs0 = 4;
    if (bits == 0) vs0 = 3;
    if (mw != 0) begin
      mul = mul * c.panel_width;
      dvd = dvd * mw;
      rmul = rmul * c.panel_width;
      rdiv = mw;
    end
    // common halving, stops on all-zero operands
    while ((mul | dvd) != 0 && ((mul | dvd) & 1) == 0) begin
      mul = mul >> 1;
      dvd = dvd >> 1;
    end
    t = qdiv((mul * c.fifo_depth) << vs0, dvd);
    prec = -5;
    while (t != 0) begin
      t = t >> 1;
      prec++;
    end
    if (prec < 0) prec = 0;
    else if (prec > 7) prec = 7;
    xs = 6 - prec;
    vs = vs0 + xs;
    off = floor_sub(qdiv(sh(mul * floor_sub(c.fifo_depth, 1), vs), dvd), 1 << vs0);
    on = qdiv(sh(mul, vs) + dvd, dvd);
    t = (sh(rmul, xs) + rdiv) / rdiv;
    if (on < t) on = t;
    on = on + t * 2 + sh(c.page_fault_delay, xs);
    unit = (((64'd1 << (7 - prec)) - 1) >> 1) + 1;
    on = ((on + unit - 1) / unit) * unit;
    if (on >= (off / unit) * unit) begin
      mq = qdiv(sh(mul, vs), dvd);
      on = floor_sub(off, mq);
      on = (on / unit) * unit;
    end
    xc = qdiv(sh(mul, vs + 5) + dvd, dvd);
    r.post_div_code = code[1:0];
    r.feedback_div = fb[7:0];
    r.fifo_on = clip16(on);
    r.fifo_off = clip16(off);
    r.fifo_precision = prec[2:0];
    r.fifo_xclks = clip16(xc);
    r.latency_out = c.loop_latency;
    return r;
  endfunction

  // Result sink: random stall bursts plus an optional long hold
  initial begin
    int stall;
    stall = 0;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_ready = 0;
        sink_hold--;
      end else if (stall > 0) begin
        out_ready = 0;
        stall--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready = 0;
        stall = $urandom_range(1, 16) - 1;
      end else begin
        out_ready = 1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (timing_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        e = timing_q.pop_front();
        if (e.out_of_range !== out_data.out_of_range ||
            e.post_div_code !== out_data.post_div_code ||
            e.feedback_div !== out_data.feedback_div ||
            e.fifo_on !== out_data.fifo_on ||
            e.fifo_off !== out_data.fifo_off ||
            e.fifo_precision !== out_data.fifo_precision ||
            e.fifo_xclks !== out_data.fifo_xclks ||
            e.latency_out !== out_data.latency_out) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  // Offer one request, hold it until accepted
  task automatic send_req(in_item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    timing_q.push_back(pll_timing(it, regs));
    @(negedge clk);
  endtask

  // Wait for every outstanding result, then let the block settle
  task automatic drain();
    in_valid = 0;
    while (timing_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write; caller ensures the block is idle
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    cfg_psel = 1; cfg_penable = 0; cfg_pwrite = 1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_REF_SCALED:   regs.ref_scaled = val[24:0];
      REG_MEM_FB_DIV:   regs.mem_fb_div = val[8:0];
      REG_MEM_POST_DIV: regs.mem_post_div = val[3:0];
      REG_RAS_DELAY:    regs.ras_delay = val[4:0];
      REG_PF_DELAY:     regs.page_fault_delay = val[4:0];
      REG_FIFO_DEPTH:   regs.fifo_depth = val[6:0];
      REG_LOOP_LAT:     regs.loop_latency = val[3:0];
      default:          regs.panel_width = val[11:0];
    endcase
    @(negedge clk);
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0;
  endtask

  function automatic in_item_t mk(int p, int b, int w);
    in_item_t it;
    it.pixel_period = 18'(p);
    it.pixel_bits = 6'(b);
    it.mode_width = 12'(w);
    return it;
  endfunction

  // Random request aimed mostly at the valid divider range
  function automatic in_item_t rand_req();
    in_item_t it;
    longint unsigned p;
    it.pixel_bits = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'(8 * $urandom_range(0, 4));
    it.mode_width = ($urandom_range(0, 1) == 0) ? 12'd0 : 12'($urandom_range(0, 4095));
    p = (longint'(regs.ref_scaled) * 4) / $urandom_range(110, 2100);
    if ($urandom_range(0, 7) == 0 || p == 0 || p > 262143)
      it.pixel_period = 18'($urandom);
    else
      it.pixel_period = p[17:0];
    return it;
  endfunction

  task automatic random_config();
    drain();
    reg_write(REG_REF_SCALED, $urandom_range(1, 33554431));
    if ($urandom_range(0, 1)) reg_write(REG_REF_SCALED, $urandom_range(200000, 16000000));
    reg_write(REG_MEM_FB_DIV, $urandom_range(0, 511));
    reg_write(REG_MEM_POST_DIV, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 15));
    reg_write(REG_RAS_DELAY, $urandom_range(0, 31));
    reg_write(REG_PF_DELAY, $urandom_range(0, 31));
    reg_write(REG_FIFO_DEPTH, $urandom_range(0, 127));
    reg_write(REG_LOOP_LAT, $urandom_range(0, 15));
    reg_write(REG_PANEL_WIDTH, $urandom_range(0, 4095));
  endtask

  // Range edges, field extremes and VGA / scaling cases at reset settings
  task automatic test_directed();
    send_req(mk(0, 8, 0));
    send_req(mk(262143, 32, 4095));
    send_req(mk(1959, 16, 0));
    send_req(mk(1960, 16, 0));
    send_req(mk(31250, 8, 0));
    send_req(mk(31251, 8, 0));
    send_req(mk(3000, 0, 0));
    send_req(mk(5000, 4, 800));
    send_req(mk(8000, 63, 4095));
    send_req(mk(15000, 32, 1));
    send_req(mk(24000, 24, 640));
    send_req(mk(2500, 1, 2048));
  endtask

  // Register extremes: zero divisor, zero depth, widest settings
  task automatic test_config_extremes();
    drain();
    reg_write(REG_MEM_POST_DIV, 0);
    reg_write(REG_FIFO_DEPTH, 0);
    send_req(mk(4000, 16, 0));
    send_req(mk(9000, 0, 1024));
    drain();
    reg_write(REG_MEM_POST_DIV, 15);
    reg_write(REG_FIFO_DEPTH, 127);
    reg_write(REG_MEM_FB_DIV, 511);
    reg_write(REG_RAS_DELAY, 31);
    reg_write(REG_PF_DELAY, 31);
    reg_write(REG_LOOP_LAT, 15);
    reg_write(REG_PANEL_WIDTH, 4095);
    send_req(mk(2000, 32, 1));
    send_req(mk(30000, 8, 4095));
    drain();
    reg_write(REG_MEM_FB_DIV, 0);
    reg_write(REG_RAS_DELAY, 0);
    reg_write(REG_PF_DELAY, 0);
    reg_write(REG_LOOP_LAT, 0);
    reg_write(REG_PANEL_WIDTH, 0);
    reg_write(REG_FIFO_DEPTH, 1);
    reg_write(REG_MEM_POST_DIV, 1);
    send_req(mk(6000, 8, 100));
    send_req(mk(6000, 0, 0));
    drain();
    reg_write(REG_REF_SCALED, 33554431);
    send_req(mk(262143, 16, 0));
    send_req(mk(65800, 16, 0));
    drain();
    reg_write(REG_REF_SCALED, 1);
    send_req(mk(1, 8, 0));
  endtask

  // Long sink hold while requests keep coming
  task automatic test_backpressure();
    drain();
    sink_hold = 3000;
    repeat (6) send_req(rand_req());
  endtask

  task automatic test_random(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      random_config();
      for (int i = 0; i < per_phase; i++) send_req(rand_req());
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0;
    cfg_paddr = '0; cfg_pwdata = '0;
    regs.ref_scaled = RST_REF_SCALED;
    regs.mem_fb_div = RST_MEM_FB_DIV;
    regs.mem_post_div = RST_MEM_POST_DIV;
    regs.ras_delay = RST_RAS_DELAY;
    regs.page_fault_delay = RST_PF_DELAY;
    regs.fifo_depth = RST_FIFO_DEPTH;
    regs.loop_latency = RST_LOOP_LAT;
    regs.panel_width = RST_PANEL_WIDTH;
    repeat (3) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random(20, 75);
    test_backpressure();
    quiet = 1;
    test_random(2, 80);
    drain();

    if (errors == 0) begin
      $display("PASS pixel_pll_and_display_fifo_timing");
    end else begin
      $display("FAIL pixel_pll_and_display_fifo_timing");
    end
    $finish;
  end
endmodule
